// ----- src/kls_pkg.sv -----
// package for the streaming top-k tracker: widths, types, register map, sequencer states
package kls_pkg;

   localparam int DATA_W     = 32;
   localparam int KEEP_W     = 7;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 2;

   typedef logic signed [DATA_W-1:0] data_type;
   typedef logic [KEEP_W-1:0]        keep_type;

   // register map, byte addresses
   localparam logic [CSR_ADDR_W-1:0] CSR_KEEP_COUNT = 2'd0;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UP_RD,
      ST_UP_CMP,
      ST_DN_RD,
      ST_DN_CMP,
      ST_DONE
   } state_type;

endpackage

// ----- src/kls_if.sv -----
// valid/ready channel interfaces for the input values and the results
interface kls_req_if;
   logic              valid;
   logic              ready;
   kls_pkg::data_type value;

   modport source (output valid, output value, input ready);
   modport sink (input valid, input value, output ready);
endinterface

interface kls_rsp_if;
   logic              valid;
   logic              ready;
   kls_pkg::data_type kth_value;
   logic              full_res;

   modport source (output valid, output kth_value, output full_res, input ready);
   modport sink (input valid, input kth_value, input full_res, output ready);
endinterface

// ----- src/kth_largest_stream_min_heap.sv -----
// A dropped value goes straight to the done state; an append or root replacement walks
// the heap a level at a time via a read and a compare state, then done loads the result
// register once the output is free. One value at a time: the heap memory (one write,
// two reads, registered) and the single compare unit are shared by all sift steps, so
// the next value waits for the last result. Reset clears the sequencer, held count
// and result valid, sets k to 1; heap entries are not cleared, read only once written.
module kth_largest_stream_min_heap #(
   parameter int MAX_KEEP = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   kls_req_if.sink                             req_ch,
   kls_rsp_if.source                           rsp_ch,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [kls_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [kls_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [kls_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                csr_pready
);

   localparam int AW  = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
   localparam int CW  = $clog2(MAX_KEEP + 1);
   localparam int KW  = (CW > kls_pkg::KEEP_W) ? CW : kls_pkg::KEEP_W;
   localparam int IW  = AW + 2;

   kls_pkg::state_type state_ff, state_in;
   logic [AW-1:0]      pos_ff, pos_in;
   logic [CW-1:0]      n_ff, n_in;
   logic [CW-1:0]      held_ff, held_in;
   kls_pkg::keep_type  keep_ff, keep_in;
   kls_pkg::data_type  cur_ff, cur_in;
   kls_pkg::data_type  root_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   kls_pkg::data_type  rsp_kth_ff, rsp_kth_in;
   logic               rsp_full_ff, rsp_full_in;

   kls_pkg::data_type  heap_mem [MAX_KEEP];
   kls_pkg::data_type  rd_a_ff, rd_b_ff;
   logic               mem_we;
   logic [AW-1:0]      mem_wa, mem_ra_a, mem_ra_b;
   kls_pkg::data_type  mem_wd;

   logic               cfg_we;
   logic [KW-1:0]      k_nz, k_lim, held_ext, held_eff;
   logic [AW-1:0]      parent;
   logic [IW-1:0]      l_idx, r_idx;
   logic               l_ok, r_ok;

   assign csr_pready = 1'b1;
   assign cfg_we     = csr_psel && csr_penable && csr_pwrite
                       && (csr_paddr == kls_pkg::CSR_KEEP_COUNT);
   assign csr_prdata = {{(kls_pkg::CSR_DATA_W - kls_pkg::KEEP_W){1'b0}}, keep_ff};

   // k of zero acts as one, k above the depth acts as the depth
   assign k_nz     = (keep_ff == '0) ? KW'(1) : KW'(keep_ff);
   assign k_lim    = (k_nz > KW'(MAX_KEEP)) ? KW'(MAX_KEEP) : k_nz;
   assign held_ext = KW'(held_ff);
   assign held_eff = (held_ext > k_lim) ? k_lim : held_ext;

   assign parent = AW'((pos_ff - 1'b1) >> 1);
   assign l_idx  = {1'b0, pos_ff, 1'b1};
   assign r_idx  = l_idx + 1'b1;
   assign l_ok   = l_idx < IW'(n_ff);
   assign r_ok   = r_idx < IW'(n_ff);

   assign req_ch.ready     = (state_ff == kls_pkg::ST_IDLE) && !cfg_we;
   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.kth_value = rsp_kth_ff;
   assign rsp_ch.full_res  = rsp_full_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         heap_mem[mem_wa] <= mem_wd;
      end
      rd_a_ff <= heap_mem[mem_ra_a];
      rd_b_ff <= heap_mem[mem_ra_b];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= kls_pkg::ST_IDLE;
         held_ff      <= '0;
         keep_ff      <= kls_pkg::keep_type'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         held_ff      <= held_in;
         keep_ff      <= keep_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff     <= pos_in;
      n_ff       <= n_in;
      cur_ff     <= cur_in;
      rsp_kth_ff <= rsp_kth_in;
      rsp_full_ff <= rsp_full_in;
      if (mem_we && (mem_wa == '0)) begin
         root_ff <= mem_wd;
      end
   end

   always_comb begin
      kls_pkg::data_type low_val;
      logic [AW-1:0]     low_pos;
      logic              moved;

      state_in     = state_ff;
      pos_in       = pos_ff;
      n_in         = n_ff;
      cur_in       = cur_ff;
      held_in      = held_ff;
      keep_in      = keep_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_kth_in   = rsp_kth_ff;
      rsp_full_in  = rsp_full_ff;
      mem_we       = 1'b0;
      mem_wa       = pos_ff;
      mem_wd       = cur_ff;
      mem_ra_a     = '0;
      mem_ra_b     = '0;
      low_val      = cur_ff;
      low_pos      = pos_ff;
      moved        = 1'b0;

      case (state_ff)
         kls_pkg::ST_IDLE: begin
            if (req_ch.valid && req_ch.ready) begin
               cur_in  = req_ch.value;
               held_in = CW'(held_eff);
               if (held_eff < k_lim) begin
                  pos_in   = AW'(held_eff);
                  held_in  = CW'(held_eff + 1'b1);
                  state_in = kls_pkg::ST_UP_RD;
               end else if (req_ch.value > root_ff) begin
                  pos_in   = '0;
                  n_in     = CW'(held_eff);
                  state_in = kls_pkg::ST_DN_RD;
               end else begin
                  state_in = kls_pkg::ST_DONE;
               end
            end
         end
         kls_pkg::ST_UP_RD: begin
            if (pos_ff == '0) begin
               mem_we   = 1'b1;
               state_in = kls_pkg::ST_DONE;
            end else begin
               mem_ra_a = parent;
               state_in = kls_pkg::ST_UP_CMP;
            end
         end
         kls_pkg::ST_UP_CMP: begin
            mem_we = 1'b1;
            // parent moves down into the hole, hole moves up
            if (rd_a_ff > cur_ff) begin
               mem_wd   = rd_a_ff;
               pos_in   = parent;
               state_in = kls_pkg::ST_UP_RD;
            end else begin
               state_in = kls_pkg::ST_DONE;
            end
         end
         kls_pkg::ST_DN_RD: begin
            if (!l_ok) begin
               mem_we   = 1'b1;
               state_in = kls_pkg::ST_DONE;
            end else begin
               mem_ra_a = (l_idx < IW'(MAX_KEEP)) ? l_idx[AW-1:0] : '0;
               mem_ra_b = (r_idx < IW'(MAX_KEEP)) ? r_idx[AW-1:0] : '0;
               state_in = kls_pkg::ST_DN_CMP;
            end
         end
         kls_pkg::ST_DN_CMP: begin
            if (l_ok && (rd_a_ff < low_val)) begin
               low_val = rd_a_ff;
               low_pos = l_idx[AW-1:0];
               moved   = 1'b1;
            end
            if (r_ok && (rd_b_ff < low_val)) begin
               low_val = rd_b_ff;
               low_pos = r_idx[AW-1:0];
               moved   = 1'b1;
            end
            mem_we = 1'b1;
            if (moved) begin
               mem_wd   = low_val;
               pos_in   = low_pos;
               state_in = kls_pkg::ST_DN_RD;
            end else begin
               state_in = kls_pkg::ST_DONE;
            end
         end
         kls_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_kth_in   = root_ff;
               rsp_full_in  = held_ext >= k_lim;
               state_in     = kls_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = kls_pkg::ST_IDLE;
         end
      endcase

      // a keep_count write empties the heap
      if (cfg_we) begin
         keep_in = csr_pwdata[kls_pkg::KEEP_W-1:0];
         held_in = '0;
      end
   end

`ifndef ASSERT_OFF
   a_held_le_k: assert property (@(posedge clock) disable iff (reset)
      held_ext <= k_lim)
      else $error("held count above k");

   a_busy_after_transfer: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> !req_ch.ready)
      else $error("input taken while a value is in progress");

   a_sink_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == kls_pkg::ST_DN_CMP) |-> (CW'(pos_ff) < n_ff))
      else $error("sift down hole outside the heap");

   a_done_after_cmp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == kls_pkg::ST_UP_CMP) |=> (state_ff == kls_pkg::ST_UP_RD
                                            || state_ff == kls_pkg::ST_DONE))
      else $error("sift up left its loop");
`endif

endmodule

// ----- tb/testbench.sv -----
// self-checking testbench for the streaming top-k tracker: directed table, then random phases
module testbench;

   localparam int HEAP_DEPTH = 64;
   localparam kls_pkg::data_type INT_MIN = 32'sh8000_0000;
   localparam kls_pkg::data_type INT_MAX = 32'sh7FFF_FFFF;

   typedef struct packed {
      logic              set_keep;
      kls_pkg::keep_type keep;
      kls_pkg::data_type value;
      logic              typed;
      kls_pkg::data_type kth;
      logic              full;
   } topk_row_type;

   typedef struct packed {
      kls_pkg::data_type kth;
      logic              full;
   } root_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [kls_pkg::CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [kls_pkg::CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [kls_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   kls_req_if req_bus();
   kls_rsp_if rsp_bus();

   kth_largest_stream_min_heap #(.MAX_KEEP(HEAP_DEPTH)) DUT (
      .clock(clock),
      .reset(reset),
      .req_ch(req_bus),
      .rsp_ch(rsp_bus),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always #10 clock = ~clock;

   // heap mirror and its settings
   kls_pkg::data_type topk_heap [HEAP_DEPTH];
   int                topk_held = 0;
   kls_pkg::keep_type topk_keep = 7'd1;

   root_result_type expected_roots [$];
   int error_count = 0;
   int value_count = 0;
   int hold_left = 0;
   logic hold_done = 1'b0;
   kls_pkg::data_type ramp_value = '0;

   // typed expectation travelling with the current directed transfer
   logic              dir_typed = 1'b0;
   kls_pkg::data_type dir_kth = '0;
   logic              dir_full = 1'b0;

   topk_row_type directed_rows [18] = '{
      '{1'b0, 7'd0,   32'sd0,          1'b1, 32'sd0,          1'b1},
      '{1'b0, 7'd0,   INT_MIN,         1'b1, 32'sd0,          1'b1},
      '{1'b0, 7'd0,   INT_MAX,         1'b1, INT_MAX,         1'b1},
      '{1'b0, 7'd0,   INT_MAX,         1'b1, INT_MAX,         1'b1},
      '{1'b1, 7'd3,   -32'sd1,         1'b1, -32'sd1,         1'b0},
      '{1'b0, 7'd0,   INT_MIN,         1'b1, INT_MIN,         1'b0},
      '{1'b0, 7'd0,   32'sd5,          1'b1, INT_MIN,         1'b1},
      '{1'b0, 7'd0,   INT_MIN,         1'b1, INT_MIN,         1'b1},
      '{1'b0, 7'd0,   32'sd7,          1'b0, 32'sd0,          1'b0},
      '{1'b0, 7'd0,   -32'sd1,         1'b1, -32'sd1,         1'b1},
      '{1'b1, 7'd0,   32'sd100,        1'b1, 32'sd100,        1'b1},
      '{1'b0, 7'd0,   32'sd99,         1'b1, 32'sd100,        1'b1},
      '{1'b1, 7'd127, INT_MAX,         1'b1, INT_MAX,         1'b0},
      '{1'b0, 7'd0,   INT_MIN,         1'b1, INT_MIN,         1'b0},
      '{1'b1, 7'd2,   32'sh5555_5555,  1'b1, 32'sh5555_5555,  1'b0},
      '{1'b0, 7'd0,   32'shAAAA_AAAA,  1'b1, 32'shAAAA_AAAA,  1'b1},
      '{1'b0, 7'd0,   32'sh7FFF_FFFE,  1'b0, 32'sd0,          1'b0},
      '{1'b1, 7'd1,   -32'sd3,         1'b1, -32'sd3,         1'b1}
   };

   kls_pkg::keep_type phase_keep [9] = '{7'd1, 7'd64, 7'd0, 7'd127, 7'd65, 7'd2, 7'd5,
                                         7'd16, 7'd0};
   int                phase_items [9] = '{50, 200, 30, 90, 40, 60, 60, 90, 80};

   function automatic int topk_limit();
      int k;
      k = topk_keep;
      if (k == 0) k = 1;
      if (k > HEAP_DEPTH) k = HEAP_DEPTH;
      return k;
   endfunction

   // one stream value into the mirror, returns the new root and full flag
   function automatic root_result_type topk_advance(input kls_pkg::data_type v);
      root_result_type res;
      kls_pkg::data_type t;
      int k, pos, up, low, l, r;
      k = topk_limit();
      if (topk_held > k) topk_held = k;
      if (topk_held < k) begin
         topk_heap[topk_held] = v;
         topk_held++;
         pos = topk_held - 1;
         while (pos > 0) begin
            up = (pos - 1) / 2;
            if (topk_heap[up] > topk_heap[pos]) begin
               t = topk_heap[up];
               topk_heap[up] = topk_heap[pos];
               topk_heap[pos] = t;
               pos = up;
            end else begin
               break;
            end
         end
      end else if (v > topk_heap[0]) begin
         topk_heap[0] = v;
         pos = 0;
         while (pos < topk_held) begin
            low = pos;
            l = 2 * pos + 1;
            r = 2 * pos + 2;
            if (l < topk_held && topk_heap[l] < topk_heap[low]) low = l;
            if (r < topk_held && topk_heap[r] < topk_heap[low]) low = r;
            if (low == pos) break;
            t = topk_heap[pos];
            topk_heap[pos] = topk_heap[low];
            topk_heap[low] = t;
            pos = low;
         end
      end
      res.kth = topk_heap[0];
      res.full = (topk_held >= k);
      return res;
   endfunction

   function automatic logic quiet_window();
      return (value_count >= 400 && value_count < 480);
   endfunction

   function automatic logic sender_pauses();
      if (quiet_window() || hold_left > 0) return 1'b0;
      return ($urandom_range(0, 99) < 24);
   endfunction

   function automatic kls_pkg::data_type pick_value();
      int small_off;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return kls_pkg::data_type'($urandom);
         4, 5: begin
            small_off = $urandom_range(0, 16);
            return kls_pkg::data_type'(small_off - 8);
         end
         6: begin
            case ($urandom_range(0, 3))
               0: return INT_MIN;
               1: return INT_MAX;
               2: return 32'sd0;
               default: return -32'sd1;
            endcase
         end
         default: begin
            // rising run forces root replacement once the heap is full
            ramp_value = ramp_value + kls_pkg::data_type'($urandom_range(1, 1000));
            return ramp_value;
         end
      endcase
   endfunction

   // all stimulus tasks start and end just after a falling edge
   task automatic send_value(input kls_pkg::data_type v, input logic typed,
                             input kls_pkg::data_type kth, input logic full);
      while (sender_pauses()) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.valid = 1'b1;
      req_bus.value = v;
      dir_typed = typed;
      dir_kth = kth;
      dir_full = full;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req_bus.valid = 1'b0;
      dir_typed = 1'b0;
      while (expected_roots.size() != 0) @(negedge clock);
   endtask

   task automatic check_keep(input kls_pkg::keep_type want);
      logic [kls_pkg::CSR_DATA_W-1:0] got;
      csr_paddr = kls_pkg::CSR_KEEP_COUNT;
      csr_pwrite = 1'b0;
      csr_psel = 1'b1;
      csr_penable = 1'b0;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      got = csr_prdata;
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      if (got !== kls_pkg::CSR_DATA_W'(want)) begin
         $error("keep_count readback mismatch: expected %0d, actual %0d", want, got);
         error_count++;
      end
   endtask

   task automatic write_keep(input kls_pkg::keep_type k);
      csr_paddr = kls_pkg::CSR_KEEP_COUNT;
      csr_pwdata = kls_pkg::CSR_DATA_W'(k);
      csr_pwrite = 1'b1;
      csr_psel = 1'b1;
      csr_penable = 1'b0;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      // a write empties the heap
      topk_keep = k;
      topk_held = 0;
      check_keep(k);
   endtask

   // result side: random stalls, one long hold-off, a quiet window
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_bus.ready = 1'b0;
         hold_left = hold_left - 1;
      end else if (!hold_done && value_count >= 150) begin
         hold_done = 1'b1;
         hold_left = 80;
         rsp_bus.ready = 1'b0;
      end else if (quiet_window()) begin
         rsp_bus.ready = 1'b1;
      end else begin
         rsp_bus.ready = ($urandom_range(0, 99) >= 24);
      end
   end

   always @(posedge clock) begin
      root_result_type predicted, want;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            predicted = topk_advance(req_bus.value);
            if (dir_typed) begin
               want.kth = dir_kth;
               want.full = dir_full;
               expected_roots.push_back(want);
            end else begin
               expected_roots.push_back(predicted);
            end
            value_count++;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_roots.size() == 0) begin
               $error("result transfer with no value pending: kth_value %0d full_res %0d",
                      rsp_bus.kth_value, rsp_bus.full_res);
               error_count++;
            end else begin
               want = expected_roots.pop_front();
               if (rsp_bus.kth_value !== want.kth) begin
                  $error("kth_value mismatch: expected %0d, actual %0d",
                         want.kth, rsp_bus.kth_value);
                  error_count++;
               end
               if (rsp_bus.full_res !== want.full) begin
                  $error("full_res mismatch: expected %0d, actual %0d",
                         want.full, rsp_bus.full_res);
                  error_count++;
               end
            end
         end
      end
   end

   initial begin
      int n, p;
      kls_pkg::keep_type k;
      req_bus.valid = 1'b0;
      req_bus.value = '0;
      repeat (3) @(negedge clock);
      reset = 1'b0;
      @(negedge clock);
      check_keep(7'd1);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].set_keep) begin
            wait_idle();
            write_keep(directed_rows[i].keep);
         end
         send_value(directed_rows[i].value, directed_rows[i].typed,
                    directed_rows[i].kth, directed_rows[i].full);
      end

      for (p = 0; p < 9; p++) begin
         k = (p == 8) ? kls_pkg::keep_type'($urandom_range(1, 64)) : phase_keep[p];
         wait_idle();
         write_keep(k);
         ramp_value = kls_pkg::data_type'(-$urandom_range(0, 1 << 20));
         for (n = 0; n < phase_items[p]; n++)
            send_value(pick_value(), 1'b0, '0, 1'b0);
      end

      wait_idle();
      repeat (40) @(negedge clock);
      if (error_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   initial begin
      #20000000;
      $display("== FAIL ==");
      $finish;
   end

endmodule

// ----- kth_largest_stream_min_heap.f -----
src/kls_pkg.sv
src/kls_if.sv
src/kth_largest_stream_min_heap.sv
tb/testbench.sv
